@@ rtl/core/lsc_pkg.sv @@
// package: types, constants and helpers for the line segment clipper
`default_nettype none
package lsc_pkg;

   localparam int CoordWidth = 16;
   localparam int CsrIndexWidth = 2;
   localparam int MaxMoves = 4;
   localparam int QueueDepth = 2;

   typedef logic signed [CoordWidth-1:0] coord_type;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_CLIP_LEFT   = 2'd0,
      CSR_CLIP_RIGHT  = 2'd1,
      CSR_CLIP_BOTTOM = 2'd2,
      CSR_CLIP_TOP    = 2'd3
   } csr_index_type;

   localparam logic [3:0] CodeLeft   = 4'b0001;
   localparam logic [3:0] CodeRight  = 4'b0010;
   localparam logic [3:0] CodeBottom = 4'b0100;
   localparam logic [3:0] CodeTop    = 4'b1000;

   localparam coord_type ResetLeft   = 16'sd3200;
   localparam coord_type ResetRight  = 16'sd9600;
   localparam coord_type ResetBottom = 16'sd2400;
   localparam coord_type ResetTop    = 16'sd7200;

   typedef struct packed {
      coord_type left;
      coord_type right;
      coord_type bottom;
      coord_type top;
   } rect_type;

   typedef struct packed {
      coord_type  sx;
      coord_type  sy;
      coord_type  ex;
      coord_type  ey;
      logic [3:0] c1;
      logic [3:0] c2;
   } seg_type;

   typedef struct packed {
      logic      accepted;
      coord_type x1;
      coord_type y1;
      coord_type x2;
      coord_type y2;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_MUL,
      ST_DIV,
      ST_UPDATE,
      ST_DONE
   } back_state_type;

   function automatic logic [3:0] outcode(input coord_type x, input coord_type y,
                                          input rect_type r);
      logic [3:0] c;
      c = 4'b0000;
      if (x < r.left) c = c | CodeLeft;
      else if (x > r.right) c = c | CodeRight;
      if (y < r.bottom) c = c | CodeBottom;
      else if (y > r.top) c = c | CodeTop;
      return c;
   endfunction

endpackage
`default_nettype wire

@@ rtl/core/lsc_front.sv @@
// front end: takes a segment, computes both outcodes, pushes into the queue
`default_nettype none
module lsc_front
   import lsc_pkg::*;
#(
   parameter int Depth = QueueDepth
) (
   input  wire        clock,
   input  wire        reset,
   input  rect_type   rect,
   input  wire        push,
   output logic       full,
   input  coord_type  sx,
   input  coord_type  sy,
   input  coord_type  ex,
   input  coord_type  ey,
   output logic       q_valid,
   input  wire        q_take,
   output seg_type    q_data
);
   localparam int PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;

   seg_type              mem_ff [Depth];
   logic [PtrWidth-1:0]  wr_ff, wr_in, rd_ff, rd_in;
   logic [PtrWidth:0]    cnt_ff, cnt_in;
   logic                 do_push, do_pop;
   seg_type              seg;

   assign full    = (cnt_ff == (PtrWidth+1)'(Depth));
   assign q_valid = (cnt_ff != '0);
   assign do_push = push && !full;
   assign do_pop  = q_take && q_valid;
   assign q_data  = mem_ff[rd_ff];

   always_comb begin
      seg.sx = sx;
      seg.sy = sy;
      seg.ex = ex;
      seg.ey = ey;
      seg.c1 = outcode(sx, sy, rect);
      seg.c2 = outcode(ex, ey, rect);
   end

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) wr_in = (wr_ff == PtrWidth'(Depth-1)) ? '0 : wr_ff + 1'b1;
      if (do_pop)  rd_in = (rd_ff == PtrWidth'(Depth-1)) ? '0 : rd_ff + 1'b1;
      if (do_push && !do_pop) cnt_in = cnt_ff + 1'b1;
      else if (!do_push && do_pop) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ff] <= seg;
   end

`ifndef NO_ASSERTIONS
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (PtrWidth+1)'(Depth))
      else $error("queue count out of range");
   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (cnt_ff == $past(cnt_ff) + 1'b1))
      else $error("queue count did not grow");
   a_pop_shrinks: assert property (@(posedge clock) disable iff (reset)
      (do_pop && !do_push) |=> (cnt_ff == $past(cnt_ff) - 1'b1))
      else $error("queue count did not shrink");
`endif

endmodule
`default_nettype wire

@@ rtl/core/lsc_divider.sv @@
// multi-cycle signed divider, restoring, one quotient bit per cycle
`default_nettype none
module lsc_divider
   import lsc_pkg::*;
#(
   parameter int Width = 48
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     start,
   input  wire signed [Width-1:0]  dividend,
   input  wire signed [Width-1:0]  divisor,
   output logic                    busy,
   output logic                    done,
   output logic signed [Width-1:0] quotient
);
   localparam int CntWidth = $clog2(Width + 1);

   logic [Width-1:0]    num_ff, num_in, den_ff, den_in;
   logic [Width:0]      rem_ff, rem_in;
   logic [CntWidth-1:0] cnt_ff, cnt_in;
   logic                neg_ff, neg_in, busy_ff, busy_in, done_ff, done_in;
   logic [Width:0]      trial;
   logic [Width-1:0]    abs_num, abs_den;

   assign abs_num = dividend[Width-1] ? Width'(-dividend) : Width'(dividend);
   assign abs_den = divisor[Width-1] ? Width'(-divisor) : Width'(divisor);
   assign trial   = {rem_ff[Width-1:0], num_ff[Width-1]} - {1'b0, den_ff};

   always_comb begin
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start && !busy_ff) begin
         num_in  = abs_num;
         den_in  = abs_den;
         rem_in  = '0;
         cnt_in  = CntWidth'(Width);
         neg_in  = dividend[Width-1] ^ divisor[Width-1];
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial[Width]) begin
            rem_in = {rem_ff[Width-1:0], num_ff[Width-1]};
            num_in = {num_ff[Width-2:0], 1'b0};
         end else begin
            rem_in = trial;
            num_in = {num_ff[Width-2:0], 1'b1};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntWidth'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      neg_ff <= neg_in;
   end

   assign busy = busy_ff;
   assign done = done_ff;
   // zero divisor gives all ones magnitude; caller forces zero then
   assign quotient = neg_ff ? -$signed(num_ff) : $signed(num_ff);

`ifndef NO_ASSERTIONS
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("divider done held");
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("divider done without busy");
   a_not_both: assert property (@(posedge clock) disable iff (reset)
      !(done_ff && busy_ff))
      else $error("divider busy and done");
`endif

endmodule
`default_nettype wire

@@ rtl/core/lsc_back.sv @@
// back end: clipping sequencer with edge interpolation and result register
`default_nettype none
module lsc_back
   import lsc_pkg::*;
(
   input  wire       clock,
   input  wire       reset,
   input  rect_type  rect,
   input  wire       q_valid,
   output logic      q_take,
   input  seg_type   q_data,
   output logic      out_valid,
   input  wire       out_pop,
   output rsp_type   out_data
);
   localparam int DivWidth = 2 * CoordWidth + 2;
   localparam int MoveWidth = $clog2(MaxMoves + 1);

   back_state_type         state_ff, state_in;
   seg_type                seg_ff, seg_in;
   coord_type              x1_ff, x1_in, y1_ff, y1_in, x2_ff, x2_in, y2_ff, y2_in;
   logic [3:0]             c1_ff, c1_in, c2_ff, c2_in;
   logic [MoveWidth-1:0]   moves_ff, moves_in;
   logic signed [DivWidth-1:0] prod_ff, prod_in, den_ff, den_in;
   logic signed [CoordWidth:0] base_ff, base_in;
   logic                   acc_ff, acc_in;
   rsp_type                rsp_ff, rsp_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   logic [3:0]                 co;
   logic                       use_first, vert;
   coord_type                  edge_v;
   logic signed [CoordWidth:0] da, num, dd;
   logic                       div_start, div_busy, div_done;
   logic signed [DivWidth-1:0] quot, q_eff;
   logic signed [DivWidth:0]   sum;
   coord_type                  sat, nx, ny;

   assign use_first = (c1_ff != 4'b0000);
   assign co        = use_first ? c1_ff : c2_ff;
   // vertical edge move (top/bottom) interpolates x
   assign vert      = (co & (CodeTop | CodeBottom)) != 4'b0000;

   always_comb begin
      priority if ((co & CodeTop) != 4'b0000) edge_v = rect.top;
      else if ((co & CodeBottom) != 4'b0000) edge_v = rect.bottom;
      else if ((co & CodeRight) != 4'b0000) edge_v = rect.right;
      else edge_v = rect.left;
      if (vert) begin
         da   = (CoordWidth+1)'(x2_ff) - (CoordWidth+1)'(x1_ff);
         num  = (CoordWidth+1)'(edge_v) - (CoordWidth+1)'(y1_ff);
         dd   = (CoordWidth+1)'(y2_ff) - (CoordWidth+1)'(y1_ff);
      end else begin
         da   = (CoordWidth+1)'(y2_ff) - (CoordWidth+1)'(y1_ff);
         num  = (CoordWidth+1)'(edge_v) - (CoordWidth+1)'(x1_ff);
         dd   = (CoordWidth+1)'(x2_ff) - (CoordWidth+1)'(x1_ff);
      end
   end

   lsc_divider #(.Width(DivWidth)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_ff),
      .divisor  (den_ff),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (quot)
   );

   assign q_eff = (den_ff == '0) ? '0 : quot;
   assign sum   = (DivWidth+1)'(base_ff) + (DivWidth+1)'(q_eff);
   always_comb begin
      if (sum > (DivWidth+1)'(32767)) sat = 16'sh7fff;
      else if (sum < -(DivWidth+1)'(32768)) sat = 16'sh8000;
      else sat = sum[CoordWidth-1:0];
      if (vert) begin
         nx = sat;
         ny = edge_v;
      end else begin
         nx = edge_v;
         ny = sat;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (q_valid) state_in = ST_CHECK;
         ST_CHECK: begin
            if ((c1_ff == 4'b0000 && c2_ff == 4'b0000) || (c1_ff & c2_ff) != 4'b0000
                || moves_ff == MoveWidth'(MaxMoves))
               state_in = ST_DONE;
            else
               state_in = ST_MUL;
         end
         ST_MUL:    state_in = ST_DIV;
         ST_DIV:    if (div_done) state_in = ST_UPDATE;
         ST_UPDATE: state_in = ST_CHECK;
         ST_DONE:   if (!rsp_valid_ff || out_pop) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      q_take       = 1'b0;
      div_start    = 1'b0;
      seg_in       = seg_ff;
      x1_in        = x1_ff;
      y1_in        = y1_ff;
      x2_in        = x2_ff;
      y2_in        = y2_ff;
      c1_in        = c1_ff;
      c2_in        = c2_ff;
      moves_in     = moves_ff;
      prod_in      = prod_ff;
      den_in       = den_ff;
      base_in      = base_ff;
      acc_in       = acc_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !out_pop;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_take   = 1'b1;
               seg_in   = q_data;
               x1_in    = q_data.sx;
               y1_in    = q_data.sy;
               x2_in    = q_data.ex;
               y2_in    = q_data.ey;
               c1_in    = q_data.c1;
               c2_in    = q_data.c2;
               moves_in = '0;
            end
         end
         ST_CHECK: acc_in = (c1_ff == 4'b0000 && c2_ff == 4'b0000);
         ST_MUL: begin
            prod_in = DivWidth'(da * num);
            den_in  = DivWidth'(dd);
            base_in = vert ? (CoordWidth+1)'(x1_ff) : (CoordWidth+1)'(y1_ff);
         end
         ST_DIV: div_start = !div_busy && !div_done;
         ST_UPDATE: begin
            moves_in = moves_ff + 1'b1;
            if (use_first) begin
               x1_in = nx;
               y1_in = ny;
               c1_in = outcode(nx, ny, rect);
            end else begin
               x2_in = nx;
               y2_in = ny;
               c2_in = outcode(nx, ny, rect);
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || out_pop) begin
               rsp_valid_in    = 1'b1;
               rsp_in.accepted = acc_ff;
               rsp_in.x1       = acc_ff ? x1_ff : seg_ff.sx;
               rsp_in.y1       = acc_ff ? y1_ff : seg_ff.sy;
               rsp_in.x2       = acc_ff ? x2_ff : seg_ff.ex;
               rsp_in.y2       = acc_ff ? y2_ff : seg_ff.ey;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         moves_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         moves_ff     <= moves_in;
      end
      seg_ff  <= seg_in;
      x1_ff   <= x1_in;
      y1_ff   <= y1_in;
      x2_ff   <= x2_in;
      y2_ff   <= y2_in;
      c1_ff   <= c1_in;
      c2_ff   <= c2_in;
      prod_ff <= prod_in;
      den_ff  <= den_in;
      base_ff <= base_in;
      acc_ff  <= acc_in;
      rsp_ff  <= rsp_in;
   end

   assign out_valid = rsp_valid_ff;
   assign out_data  = rsp_ff;

`ifndef NO_ASSERTIONS
   a_moves_bound: assert property (@(posedge clock) disable iff (reset)
      moves_ff <= MoveWidth'(MaxMoves))
      else $error("too many moves");
   a_take_idle: assert property (@(posedge clock) disable iff (reset)
      q_take |-> (state_ff == ST_IDLE && q_valid))
      else $error("queue taken outside idle");
   a_update_after_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPDATE) |-> $past(div_done))
      else $error("update without quotient");
`endif

endmodule
`default_nettype wire

@@ rtl/core/line_segment_clipper_core.sv @@
// top level: clip rectangle registers, front end, back end
//
// channel   ports               handshake
// request   req_start_x..end_y  push / full
// response  rsp_accepted..      empty / pop
// csr       csr_index/data      csr_write_enable, no wait
//
// a trivially decided segment passes idle, check and done; each edge move (up to four)
// adds the mul, div and update states, div waiting on the 34-bit one-bit-per-cycle divider.
// synchronous active-high reset empties the queue and loads the default rectangle.
// the front queue takes requests while the back end works or the result waits.
`default_nettype none
module line_segment_clipper_core
   import lsc_pkg::*;
#(
   parameter int Depth = QueueDepth
) (
   input  wire        clock,
   input  wire        reset,
   input  wire        push,
   output logic       full,
   input  coord_type  req_start_x,
   input  coord_type  req_start_y,
   input  coord_type  req_end_x,
   input  coord_type  req_end_y,
   output logic       empty,
   input  wire        pop,
   output logic       rsp_accepted,
   output coord_type  rsp_clipped_start_x,
   output coord_type  rsp_clipped_start_y,
   output coord_type  rsp_clipped_end_x,
   output coord_type  rsp_clipped_end_y,
   input  wire        csr_write_enable,
   input  wire [CsrIndexWidth-1:0] csr_index,
   input  wire [CoordWidth-1:0]    csr_data
);
   rect_type rect_ff, rect_in;
   logic     q_valid, q_take, out_valid;
   seg_type  q_data;
   rsp_type  out_data;

   always_comb begin
      rect_in = rect_ff;
      if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_CLIP_LEFT:   rect_in.left   = csr_data;
            CSR_CLIP_RIGHT:  rect_in.right  = csr_data;
            CSR_CLIP_BOTTOM: rect_in.bottom = csr_data;
            CSR_CLIP_TOP:    rect_in.top    = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rect_ff.left   <= ResetLeft;
         rect_ff.right  <= ResetRight;
         rect_ff.bottom <= ResetBottom;
         rect_ff.top    <= ResetTop;
      end else begin
         rect_ff <= rect_in;
      end
   end

   lsc_front #(.Depth(Depth)) u_front (
      .clock   (clock),
      .reset   (reset),
      .rect    (rect_ff),
      .push    (push),
      .full    (full),
      .sx      (req_start_x),
      .sy      (req_start_y),
      .ex      (req_end_x),
      .ey      (req_end_y),
      .q_valid (q_valid),
      .q_take  (q_take),
      .q_data  (q_data)
   );

   lsc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .rect      (rect_ff),
      .q_valid   (q_valid),
      .q_take    (q_take),
      .q_data    (q_data),
      .out_valid (out_valid),
      .out_pop   (pop),
      .out_data  (out_data)
   );

   assign empty               = !out_valid;
   assign rsp_accepted        = out_data.accepted;
   assign rsp_clipped_start_x = out_data.x1;
   assign rsp_clipped_start_y = out_data.y1;
   assign rsp_clipped_end_x   = out_data.x2;
   assign rsp_clipped_end_y   = out_data.y2;

`ifndef NO_ASSERTIONS
   a_reset_rect: assert property (@(posedge clock)
      $past(reset) |-> (rect_ff.left == ResetLeft && rect_ff.top == ResetTop))
      else $error("rectangle not reset");
   a_csr_hold: assert property (@(posedge clock) disable iff (reset)
      !csr_write_enable |=> $stable(rect_ff))
      else $error("rectangle changed without write");
   a_empty_reset: assert property (@(posedge clock)
      $past(reset) |-> empty)
      else $error("result after reset");
`endif

endmodule
`default_nettype wire

@@ tb/line_segment_clipper_core_tb.sv @@
// testbench: line segment clipper core checked against its own clipping predictor
`timescale 1ns / 1ps
module line_segment_clipper_core_tb;
   import lsc_pkg::*;

   localparam int WatchdogLimit = 4000;
   localparam int HoldCycles = 500;
   localparam int DrainCycles = 300;
   localparam int ItemsPerPhase = 130;

   typedef struct {
      coord_type sx;
      coord_type sy;
      coord_type ex;
      coord_type ey;
   } segment_type;

   class clip_scoreboard;
      int left, right, bottom, top;
      rsp_type expected_q[$];
      int errors;

      function new();
         left = ResetLeft;
         right = ResetRight;
         bottom = ResetBottom;
         top = ResetTop;
         errors = 0;
      endfunction

      function void set_edge(csr_index_type idx, coord_type v);
         case (idx)
            CSR_CLIP_LEFT:   left = v;
            CSR_CLIP_RIGHT:  right = v;
            CSR_CLIP_BOTTOM: bottom = v;
            CSR_CLIP_TOP:    top = v;
         endcase
      endfunction

      function logic [3:0] region_code(int x, int y);
         logic [3:0] c;
         c = 4'b0000;
         if (x < left) c = c | CodeLeft;
         else if (x > right) c = c | CodeRight;
         if (y < bottom) c = c | CodeBottom;
         else if (y > top) c = c | CodeTop;
         return c;
      endfunction

      // a0 + da*num/den, truncating toward zero, saturated to 16 bits
      function int edge_cross(int a0, int da, int num, int den);
         longint q, r;
         q = 0;
         if (den != 0) q = (longint'(da) * longint'(num)) / longint'(den);
         r = longint'(a0) + q;
         if (r > 32767) r = 32767;
         if (r < -32768) r = -32768;
         return int'(r);
      endfunction

      function rsp_type clip_segment(segment_type s);
         int x1, y1, x2, y2, nx, ny;
         logic [3:0] c1, c2, co;
         bit ok;
         rsp_type r;
         x1 = s.sx; y1 = s.sy; x2 = s.ex; y2 = s.ey;
         c1 = region_code(x1, y1);
         c2 = region_code(x2, y2);
         ok = 0;
         for (int moves = 0; moves <= MaxMoves; moves++) begin
            if (c1 == 0 && c2 == 0) begin
               ok = 1;
               break;
            end
            if ((c1 & c2) != 0 || moves == MaxMoves) break;
            co = (c1 != 0) ? c1 : c2;
            if (co & CodeTop) begin
               nx = edge_cross(x1, x2 - x1, top - y1, y2 - y1);
               ny = top;
            end else if (co & CodeBottom) begin
               nx = edge_cross(x1, x2 - x1, bottom - y1, y2 - y1);
               ny = bottom;
            end else if (co & CodeRight) begin
               ny = edge_cross(y1, y2 - y1, right - x1, x2 - x1);
               nx = right;
            end else begin
               ny = edge_cross(y1, y2 - y1, left - x1, x2 - x1);
               nx = left;
            end
            if (co == c1) begin
               x1 = nx; y1 = ny; c1 = region_code(x1, y1);
            end else begin
               x2 = nx; y2 = ny; c2 = region_code(x2, y2);
            end
         end
         if (!ok) begin
            x1 = s.sx; y1 = s.sy; x2 = s.ex; y2 = s.ey;
         end
         r.accepted = ok;
         r.x1 = coord_type'(x1);
         r.y1 = coord_type'(y1);
         r.x2 = coord_type'(x2);
         r.y2 = coord_type'(y2);
         return r;
      endfunction

      function void note_request(segment_type s);
         expected_q.push_back(clip_segment(s));
      endfunction

      function void check_response(rsp_type act);
         rsp_type exp_r;
         if (expected_q.size() == 0) begin
            $error("response with no request outstanding");
            errors++;
            return;
         end
         exp_r = expected_q.pop_front();
         if (act.accepted !== exp_r.accepted) begin
            $error("accepted: expected %0d, got %0d", exp_r.accepted, act.accepted);
            errors++;
         end
         if (act.x1 !== exp_r.x1) begin
            $error("clipped_start_x: expected %0d, got %0d", exp_r.x1, act.x1);
            errors++;
         end
         if (act.y1 !== exp_r.y1) begin
            $error("clipped_start_y: expected %0d, got %0d", exp_r.y1, act.y1);
            errors++;
         end
         if (act.x2 !== exp_r.x2) begin
            $error("clipped_end_x: expected %0d, got %0d", exp_r.x2, act.x2);
            errors++;
         end
         if (act.y2 !== exp_r.y2) begin
            $error("clipped_end_y: expected %0d, got %0d", exp_r.y2, act.y2);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic push = 0;
   logic pop = 0;
   logic full, empty;
   coord_type req_start_x = '0, req_start_y = '0, req_end_x = '0, req_end_y = '0;
   logic rsp_accepted;
   coord_type rsp_clipped_start_x, rsp_clipped_start_y;
   coord_type rsp_clipped_end_x, rsp_clipped_end_y;
   logic csr_write_enable = 0;
   logic [CsrIndexWidth-1:0] csr_index = '0;
   logic [CoordWidth-1:0] csr_data = '0;

   clip_scoreboard sb = new();
   int idle_cycles = 0;
   int pops_done = 0;

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   line_segment_clipper_core u_top (
      .clock(clock), .reset(reset),
      .push(push), .full(full),
      .req_start_x(req_start_x), .req_start_y(req_start_y),
      .req_end_x(req_end_x), .req_end_y(req_end_y),
      .empty(empty), .pop(pop),
      .rsp_accepted(rsp_accepted),
      .rsp_clipped_start_x(rsp_clipped_start_x),
      .rsp_clipped_start_y(rsp_clipped_start_y),
      .rsp_clipped_end_x(rsp_clipped_end_x),
      .rsp_clipped_end_y(rsp_clipped_end_y),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   // watchdog on cycles with no request or response moving
   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic send_segment(segment_type s, int gap);
      if (gap > 0) begin
         push = 0;
         repeat (gap) @(negedge clock);
      end
      push = 1;
      req_start_x = s.sx;
      req_start_y = s.sy;
      req_end_x = s.ex;
      req_end_y = s.ey;
      do @(posedge clock); while (full);
      sb.note_request(s);
      @(negedge clock);
   endtask

   task automatic write_edge(csr_index_type idx, coord_type v);
      csr_write_enable = 1;
      csr_index = idx;
      csr_data = v;
      sb.set_edge(idx, v);
      @(negedge clock);
      csr_write_enable = 0;
   endtask

   task automatic set_rect(coord_type l, coord_type r, coord_type b, coord_type t);
      write_edge(CSR_CLIP_LEFT, l);
      write_edge(CSR_CLIP_RIGHT, r);
      write_edge(CSR_CLIP_BOTTOM, b);
      write_edge(CSR_CLIP_TOP, t);
   endtask

   task automatic wait_drained();
      push = 0;
      while (sb.expected_q.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   // mostly within the rectangle span widened by 64 or 4000, sometimes anywhere
   function automatic coord_type pick_coord(int a, int b);
      int lo, hi, m;
      if ($urandom_range(3) == 0) return coord_type'($urandom);
      m = $urandom_range(1) ? 64 : 4000;
      lo = ((a < b) ? a : b) - m;
      hi = ((a < b) ? b : a) + m;
      if (lo < -32768) lo = -32768;
      if (hi > 32767) hi = 32767;
      return coord_type'(lo + int'($urandom_range(hi - lo)));
   endfunction

   task automatic random_phase(int n);
      segment_type s;
      repeat (n) begin
         s.sx = pick_coord(sb.left, sb.right);
         s.sy = pick_coord(sb.bottom, sb.top);
         s.ex = pick_coord(sb.left, sb.right);
         s.ey = pick_coord(sb.bottom, sb.top);
         send_segment(s, ($urandom_range(3) == 0) ? 0 : $urandom_range(18));
      end
      wait_drained();
   endtask

   // response side: random stalls plus long hold-offs so the input backs up
   initial begin
      int gap;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(18);
         if (pops_done == 200 || pops_done == 600) gap = HoldCycles;
         if (gap > 0) begin
            pop = 0;
            repeat (gap) @(negedge clock);
         end
         pop = 1;
         do @(posedge clock); while (empty);
         sb.check_response('{rsp_accepted, rsp_clipped_start_x, rsp_clipped_start_y,
                             rsp_clipped_end_x, rsp_clipped_end_y});
         pops_done++;
         @(negedge clock);
      end
   end

   initial begin
      segment_type directed[$];
      int l, r;
      directed = '{
         '{16'sd4000, 16'sd3000, 16'sd8000, 16'sd7000},
         '{16'sd0, 16'sd0, 16'sd1000, 16'sd9000},
         '{16'sd0, 16'sd4000, 16'sd12000, 16'sd4000},
         '{16'sd5000, 16'sd0, 16'sd5000, 16'sd10000},
         '{16'sd12000, 16'sd5000, 16'sd0, 16'sd5000},
         '{16'sd5000, 16'sd10000, 16'sd5000, 16'sd0},
         '{16'sd0, 16'sd6000, 16'sd4000, 16'sd10000},
         '{16'sd2000, 16'sd8000, 16'sd11000, 16'sd1000},
         '{-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767},
         '{-16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768},
         '{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768},
         '{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767},
         '{16'sd3200, 16'sd2400, 16'sd9600, 16'sd7200},
         '{16'sd3199, 16'sd2399, 16'sd9601, 16'sd7201},
         '{16'sd0, 16'sd0, 16'sd0, 16'sd0},
         '{16'sd6000, 16'sd5000, 16'sd6000, 16'sd5000},
         '{16'sd6000, 16'sd5000, 16'sd20000, 16'sd30000},
         '{16'sd2000, 16'sd3000, 16'sd4000, 16'sd1000},
         '{16'sd9000, 16'sd8000, 16'sd10000, 16'sd6000}
      };
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 0;
      @(negedge clock);
      foreach (directed[i]) send_segment(directed[i], i % 3);
      wait_drained();
      random_phase(ItemsPerPhase);
      set_rect(-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767);
      random_phase(ItemsPerPhase);
      set_rect(16'sd0, 16'sd0, 16'sd0, 16'sd0);
      random_phase(ItemsPerPhase);
      // inverted rectangle: exercises saturation and the move limit
      set_rect(16'sd9600, 16'sd3200, 16'sd7200, 16'sd2400);
      random_phase(ItemsPerPhase);
      set_rect(-16'sd16, 16'sd16, -16'sd16, 16'sd16);
      random_phase(ItemsPerPhase);
      set_rect(16'sd32000, 16'sd32767, -16'sd32768, -16'sd32000);
      random_phase(ItemsPerPhase);
      l = $urandom_range(65535) - 32768;
      r = l + int'($urandom_range(32767 - l));
      write_edge(CSR_CLIP_LEFT, coord_type'(l));
      write_edge(CSR_CLIP_RIGHT, coord_type'(r));
      l = $urandom_range(65535) - 32768;
      r = l + int'($urandom_range(32767 - l));
      write_edge(CSR_CLIP_BOTTOM, coord_type'(l));
      write_edge(CSR_CLIP_TOP, coord_type'(r));
      random_phase(ItemsPerPhase);
      set_rect(coord_type'($urandom), coord_type'($urandom),
               coord_type'($urandom), coord_type'($urandom));
      random_phase(ItemsPerPhase);
      repeat (DrainCycles) @(negedge clock);
      if (sb.expected_q.size() != 0) begin
         $error("%0d responses never arrived", sb.expected_q.size());
         sb.errors++;
      end
      if (sb.errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
